// File: design/dac_pkg.sv
// Shared types, constants and helpers for the displacement admission control unit.
package dac_pkg;

  // Symbol table geometry
  localparam int unsigned NUM_SYMBOLS = 4096;
  localparam int unsigned SYM_IDX_W   = $clog2(NUM_SYMBOLS);
  localparam int unsigned SYM_W       = 12;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned EPOCH_W     = 8;

  localparam logic [SYM_W-1:0]   SYM_NONE = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned DEFAULT_HOLD_SECONDS = 60;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISPLACEMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_SECONDS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS      = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADMIT    = 2'd0,
    REQ_DISPLACE = 2'd1,
    REQ_DAY_CLR  = 2'd2,
    REQ_CHECK    = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OPEN     = 2'd0,
    ST_COOLING  = 2'd1,
    ST_RESERVED = 2'd2,
    ST_LIMIT    = 2'd3
  } status_e_t;

  typedef struct packed {
    req_e_t             req_type;
    logic [SYM_W-1:0]   symbol;
    logic [SYM_W-1:0]   beneficiary;
    logic [TIME_W-1:0]  now;
  } in_item_t;

  typedef struct packed {
    status_e_t          status;
    logic [SYM_W-1:0]   reserved_symbol;
    logic [TIME_W-1:0]  seconds_left;
    logic [COUNT_W-1:0] displacement_count;
  } result_t;

  // One cooldown table entry; live only while armed and tagged with the current day
  typedef struct packed {
    logic               armed;
    logic [EPOCH_W-1:0] epoch;
    logic [TIME_W-1:0]  expiry;
  } cool_entry_t;

  typedef struct packed {
    logic                 en;
    logic [SYM_IDX_W-1:0] addr;
    cool_entry_t          entry;
  } cool_wr_t;

  // Add a duration to a time, saturating at the largest time
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [TIME_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

// File: design/dac_in_if.sv
// Request channel interface: valid/ready handshake with the request fields.
interface dac_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [dac_pkg::SYM_W-1:0]   symbol;
  logic [dac_pkg::SYM_W-1:0]   beneficiary;
  logic [dac_pkg::TIME_W-1:0]  now;

  modport source (output valid, req_type, symbol, beneficiary, now, input ready);
  modport sink   (input valid, req_type, symbol, beneficiary, now, output ready);
endinterface

// File: design/dac_out_if.sv
// Result channel interface: valid/ready handshake with the result fields.
interface dac_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [dac_pkg::SYM_W-1:0]   reserved_symbol;
  logic [dac_pkg::TIME_W-1:0]  seconds_left;
  logic [dac_pkg::COUNT_W-1:0] displacement_count;

  modport source (output valid, status, reserved_symbol, seconds_left, displacement_count,
                  input ready);
  modport sink   (input valid, status, reserved_symbol, seconds_left, displacement_count,
                  output ready);
endinterface

// File: design/dac_cool_store.sv
// Cooldown table memory with write-to-read bypass and a clearing sweep.
module dac_cool_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [dac_pkg::SYM_IDX_W-1:0] rd_addr,
  output dac_pkg::cool_entry_t          rd_entry,
  input  dac_pkg::cool_wr_t             wr,
  input  logic                          sweep_start,
  output logic                          busy
);

  dac_pkg::cool_entry_t mem [dac_pkg::NUM_SYMBOLS];

  dac_pkg::cool_entry_t          mem_q_r;
  dac_pkg::cool_entry_t          byp_r;
  logic                          byp_hit_r;
  logic                          sweep_r;
  logic [dac_pkg::SYM_IDX_W-1:0] sweep_addr_r;
  dac_pkg::cool_wr_t             wr_eff;

  // Sweep owns the write port while it runs
  always_comb begin
    if (sweep_r) begin
      wr_eff.en    = 1'b1;
      wr_eff.addr  = sweep_addr_r;
      wr_eff.entry = '0;
    end else begin
      wr_eff = wr;
    end
  end

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_eff.en) begin
      mem[wr_eff.addr] <= wr_eff.entry;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      byp_r   <= wr_eff.entry;
    end
  end

  // Remember a read that collided with a write in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (rd_en) begin
      byp_hit_r <= wr_eff.en && (wr_eff.addr == rd_addr);
    end
  end

  // Clear every entry after reset and on request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
    end else if (sweep_r) begin
      sweep_addr_r <= sweep_addr_r + 1'b1;
      if (sweep_addr_r == dac_pkg::SYM_IDX_W'(dac_pkg::NUM_SYMBOLS - 1)) begin
        sweep_r <= 1'b0;
      end
    end else if (sweep_start) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
    end
  end

  assign rd_entry = byp_hit_r ? byp_r : mem_q_r;
  assign busy     = sweep_r;

endmodule

// File: design/dac_core.sv
// Decision logic, configuration registers and reservation/count state.
module dac_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  dac_pkg::in_item_t             item,
  input  logic                          advance,
  input  dac_pkg::cool_entry_t          entry,
  output dac_pkg::result_t              result,
  output dac_pkg::cool_wr_t             wr,
  output logic                          sweep_start,
  output logic                          epoch_last
);

  logic [dac_pkg::COUNT_W-1:0] max_disp_r;
  logic [15:0]                 cooldown_r;
  logic [15:0]                 hold_r;

  logic [dac_pkg::SYM_W-1:0]   rsv_for_r, rsv_for_nxt;
  logic [dac_pkg::TIME_W-1:0]  rsv_until_r, rsv_until_nxt;
  logic [dac_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic [dac_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;

  logic                        in_table;
  logic                        live;
  logic                        cooling;
  logic [dac_pkg::TIME_W-1:0]  hold_time;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r <= '0;
      cooldown_r <= '0;
      hold_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dac_pkg::CFG_MAX_DISPLACEMENTS: max_disp_r <= cfg_data[dac_pkg::COUNT_W-1:0];
        dac_pkg::CFG_COOLDOWN_SECONDS:  cooldown_r <= cfg_data;
        dac_pkg::CFG_HOLD_SECONDS:      hold_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_table  = 32'(item.symbol) < dac_pkg::NUM_SYMBOLS;
  assign live      = in_table && entry.armed && (entry.epoch == epoch_r);
  assign cooling   = live && (item.now < entry.expiry);
  assign hold_time = (hold_r != '0) ? 32'(hold_r) : 32'(dac_pkg::DEFAULT_HOLD_SECONDS);
  assign epoch_last = &epoch_r;

  // Decide the result and the next state for the item in the stage
  always_comb begin
    rsv_for_nxt   = rsv_for_r;
    rsv_until_nxt = rsv_until_r;
    total_nxt     = total_r;
    epoch_nxt     = epoch_r;
    result.status          = dac_pkg::ST_OPEN;
    result.reserved_symbol = dac_pkg::SYM_NONE;
    result.seconds_left    = '0;
    wr.en    = 1'b0;
    wr.addr  = dac_pkg::SYM_IDX_W'(item.symbol);
    wr.entry = '0;
    sweep_start = 1'b0;

    unique case (item.req_type)
      dac_pkg::REQ_ADMIT: begin
        // drop an expired cooldown
        if (live && !cooling) begin
          wr.en = advance;
        end
        if (cooling) begin
          result.status = dac_pkg::ST_COOLING;
        end else if (rsv_for_r != dac_pkg::SYM_NONE) begin
          if (item.now >= rsv_until_r || rsv_for_r == item.symbol) begin
            rsv_for_nxt = dac_pkg::SYM_NONE;
          end else begin
            result.status          = dac_pkg::ST_RESERVED;
            result.reserved_symbol = rsv_for_r;
          end
        end
      end
      dac_pkg::REQ_DISPLACE: begin
        if (total_r != dac_pkg::COUNT_MAX) begin
          total_nxt = total_r + 1'b1;
        end
        // arm the victim's cooldown
        if (cooldown_r != '0 && item.symbol != dac_pkg::SYM_NONE && in_table) begin
          wr.en           = advance;
          wr.entry.armed  = 1'b1;
          wr.entry.epoch  = epoch_r;
          wr.entry.expiry = dac_pkg::sat_add(item.now, 32'(cooldown_r));
        end
        rsv_for_nxt   = item.beneficiary;
        rsv_until_nxt = dac_pkg::sat_add(item.now, hold_time);
      end
      dac_pkg::REQ_DAY_CLR: begin
        // new day tag retires all armed entries at once
        rsv_for_nxt   = dac_pkg::SYM_NONE;
        rsv_until_nxt = '0;
        total_nxt     = '0;
        epoch_nxt     = epoch_r + 1'b1;
        sweep_start   = advance && epoch_last;
      end
      dac_pkg::REQ_CHECK: begin
        priority if (max_disp_r != '0 && total_r >= max_disp_r) begin
          result.status = dac_pkg::ST_LIMIT;
        end else if (rsv_for_r != dac_pkg::SYM_NONE && item.now < rsv_until_r) begin
          result.status          = dac_pkg::ST_RESERVED;
          result.reserved_symbol = rsv_for_r;
          result.seconds_left    = rsv_until_r - item.now;
        end else if (cooling) begin
          result.status       = dac_pkg::ST_COOLING;
          result.seconds_left = entry.expiry - item.now;
        end else begin
          result.status = dac_pkg::ST_OPEN;
        end
      end
      default: ;
    endcase

    result.displacement_count = total_nxt;
  end

  // Commit state when the item leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_for_r   <= dac_pkg::SYM_NONE;
      rsv_until_r <= '0;
      total_r     <= '0;
      epoch_r     <= '0;
    end else if (advance) begin
      rsv_for_r   <= rsv_for_nxt;
      rsv_until_r <= rsv_until_nxt;
      total_r     <= total_nxt;
      epoch_r     <= epoch_nxt;
    end
  end

endmodule

// File: design/displacement_admission_control_unit.sv
// Top level of the displacement admission control unit: stage, result register, handshake.
//
// Each request is registered together with a read of its symbol's cooldown entry, decided in
// the stage and moved into the result register when that is free or being emptied, and one
// request can be taken every cycle while the result register is not stalled and no clearing
// pass runs; a request that reads the entry its predecessor writes in the same cycle gets
// the written value through a bypass. After reset the table is cleared by a pass over all
// 4096 entries during which no request is taken (configuration writes still are). A daily
// reset retires all cooldowns at once by bumping an 8-bit day tag; every 256th daily reset
// the tag wraps, and the same clearing pass runs before the next request is taken.
module displacement_admission_control_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  dac_in_if.sink                         in_ch,
  dac_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [dac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dac_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 s1_valid_r;
  dac_pkg::in_item_t    s1_item_r;
  logic                 out_valid_r;
  dac_pkg::result_t     out_res_r;

  logic                 advance;
  logic                 accept;
  logic                 busy;
  logic                 wrap_hold;
  logic                 sweep_start;
  logic                 epoch_last;
  dac_pkg::in_item_t    in_item;
  dac_pkg::cool_entry_t entry;
  dac_pkg::cool_wr_t    wr;
  dac_pkg::result_t     result;

  assign in_item.req_type    = dac_pkg::req_e_t'(in_ch.req_type);
  assign in_item.symbol      = in_ch.symbol;
  assign in_item.beneficiary = in_ch.beneficiary;
  assign in_item.now         = in_ch.now;

  // Stage moves on when the result register is free or being emptied
  assign advance   = s1_valid_r && (!out_valid_r || out_ch.ready);
  // Hold off new requests behind a day reset that wraps the day tag
  assign wrap_hold = s1_valid_r && (s1_item_r.req_type == dac_pkg::REQ_DAY_CLR) && epoch_last;
  assign in_ch.ready = !busy && !wrap_hold && (!s1_valid_r || advance);
  assign accept      = in_ch.valid && in_ch.ready;

  dac_cool_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (accept),
    .rd_addr     (dac_pkg::SYM_IDX_W'(in_ch.symbol)),
    .rd_entry    (entry),
    .wr          (wr),
    .sweep_start (sweep_start),
    .busy        (busy)
  );

  dac_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (s1_item_r),
    .advance     (advance),
    .entry       (entry),
    .result      (result),
    .wr          (wr),
    .sweep_start (sweep_start),
    .epoch_last  (epoch_last)
  );

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_res_r.status;
  assign out_ch.reserved_symbol    = out_res_r.reserved_symbol;
  assign out_ch.seconds_left       = out_res_r.seconds_left;
  assign out_ch.displacement_count = out_res_r.displacement_count;

  // A displacement always leaves a nonzero count in its result
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_item_r.req_type == dac_pkg::REQ_DISPLACE)
    |=> out_res_r.displacement_count != '0)
    else $error("displacement result carries a zero count");

  // A reserved answer names a real symbol
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == dac_pkg::ST_RESERVED)
    |-> out_res_r.reserved_symbol != dac_pkg::SYM_NONE)
    else $error("reserved status without a reserving symbol");

  // A day-tag wrap starts the clearing pass before any further transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && wrap_hold |=> busy && !in_ch.ready)
    else $error("day tag wrapped without a clearing pass");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the displacement admission control unit.
import dac_pkg::*;

// Track the admission state, predict each verdict and compare against the block output
class verdict_board;
  logic [COUNT_W-1:0] day_cap;
  logic [15:0]        cool_secs;
  logic [15:0]        hold_secs;

  bit                 armed [NUM_SYMBOLS];
  logic [TIME_W-1:0]  expiry[NUM_SYMBOLS];
  logic [SYM_W-1:0]   resv_sym;
  logic [TIME_W-1:0]  resv_until;
  logic [COUNT_W-1:0] day_total;

  result_t     expected_verdicts[$];
  int unsigned errors;
  int unsigned compared;
  int unsigned req_seen[4];
  int unsigned status_seen[4];

  function new();
    day_cap     = '0;
    cool_secs   = '0;
    hold_secs   = '0;
    errors      = 0;
    compared    = 0;
    clear_day();
  endfunction

  function void clear_day();
    foreach (armed[i]) armed[i] = 1'b0;
    resv_sym   = SYM_NONE;
    resv_until = '0;
    day_total  = '0;
  endfunction

  function void set_limits(logic [COUNT_W-1:0] lim, logic [15:0] cool, logic [15:0] hold);
    day_cap     = lim;
    cool_secs   = cool;
    hold_secs   = hold;
  endfunction

  // Add a duration, pinning at the largest time on overflow
  function logic [TIME_W-1:0] time_plus(logic [TIME_W-1:0] t, logic [TIME_W-1:0] d);
    return (t > 32'hFFFF_FFFF - d) ? 32'hFFFF_FFFF : t + d;
  endfunction

  function int unsigned pending();
    return expected_verdicts.size();
  endfunction

  // Apply one accepted request to the tracked state and queue its verdict
  function void note_request(in_item_t rq);
    result_t           v;
    logic [TIME_W-1:0] hold;
    v.status             = ST_OPEN;
    v.reserved_symbol    = SYM_NONE;
    v.seconds_left       = '0;
    req_seen[rq.req_type]++;
    case (rq.req_type)
      REQ_ADMIT: begin
        if (armed[rq.symbol] && rq.now < expiry[rq.symbol]) begin
          v.status = ST_COOLING;
        end else begin
          // expired cooldown retires here
          armed[rq.symbol] = 1'b0;
          if (resv_sym != SYM_NONE) begin
            if (rq.now >= resv_until || resv_sym == rq.symbol) begin
              resv_sym = SYM_NONE;
            end else begin
              v.status          = ST_RESERVED;
              v.reserved_symbol = resv_sym;
            end
          end
        end
      end
      REQ_DISPLACE: begin
        if (day_total != COUNT_MAX) day_total++;
        if (cool_secs != 0 && rq.symbol != SYM_NONE) begin
          expiry[rq.symbol] = time_plus(rq.now, 32'(cool_secs));
          armed[rq.symbol]  = 1'b1;
        end
        hold       = (hold_secs != 0) ? 32'(hold_secs) : 32'(DEFAULT_HOLD_SECONDS);
        resv_sym   = rq.beneficiary;
        resv_until = time_plus(rq.now, hold);
      end
      REQ_DAY_CLR: begin
        clear_day();
      end
      default: begin
        if (day_cap != 0 && day_total >= day_cap) begin
          v.status = ST_LIMIT;
        end else if (resv_sym != SYM_NONE && rq.now < resv_until) begin
          v.status          = ST_RESERVED;
          v.reserved_symbol = resv_sym;
          v.seconds_left    = resv_until - rq.now;
        end else if (armed[rq.symbol] && rq.now < expiry[rq.symbol]) begin
          v.status       = ST_COOLING;
          v.seconds_left = expiry[rq.symbol] - rq.now;
        end
      end
    endcase
    v.displacement_count = day_total;
    expected_verdicts.insert(expected_verdicts.size(), v);
  endfunction

  function void mismatch(string field, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
    errors++;
    if (errors <= 20)
      $error("%s: expected %0d, actual %0d (result %0d)", field, exp_v, act_v, compared);
  endfunction

  // Compare one transferred result with the oldest queued verdict
  function void check_verdict(result_t got);
    result_t want;
    if (expected_verdicts.size() == 0) begin
      errors++;
      if (errors <= 20) $error("result with no request outstanding");
      return;
    end
    want = expected_verdicts.pop_front();
    status_seen[want.status]++;
    if (got.status !== want.status) mismatch("status", 32'(want.status), 32'(got.status));
    if (got.reserved_symbol !== want.reserved_symbol)
      mismatch("reserved_symbol", 32'(want.reserved_symbol), 32'(got.reserved_symbol));
    if (got.seconds_left !== want.seconds_left)
      mismatch("seconds_left", want.seconds_left, got.seconds_left);
    if (got.displacement_count !== want.displacement_count)
      mismatch("displacement_count", 32'(want.displacement_count),
               32'(got.displacement_count));
    compared++;
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dac_in_if  in_ch ();
  dac_out_if out_ch ();

  verdict_board      board = new();
  logic [TIME_W-1:0] t_clock;
  bit                no_idle;
  bit                hold_off_req;
  int                cycles = 0;
  int                settings_used;

  displacement_admission_control_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Favor a small pool so cooldowns and reservations collide
  function automatic logic [SYM_W-1:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SYM_W'($urandom_range(0, 7));
    if (r < 80) return SYM_NONE;
    if (r < 85) return SYM_NONE - 1'b1;
    if (r < 90) return '0;
    return SYM_W'($urandom_range(0, NUM_SYMBOLS - 1));
  endfunction

  // Advance time mostly in small steps, with jumps and runs near the top
  function automatic logic [TIME_W-1:0] advance_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) t_clock = t_clock + $urandom_range(0, 15);
    else if (r < 92) t_clock = t_clock + $urandom_range(16, 400);
    else if (r < 96) t_clock = $urandom();
    else t_clock = 32'hFFFF_FFFF - $urandom_range(0, 100);
    return t_clock;
  endfunction

  // Offer one request and hold it until transferred
  task automatic issue(input req_e_t kind, input logic [SYM_W-1:0] sym,
                       input logic [SYM_W-1:0] ben, input logic [TIME_W-1:0] at);
    in_item_t rq;
    int       gap;
    rq.req_type    = kind;
    rq.symbol      = sym;
    rq.beneficiary = ben;
    rq.now         = at;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq.req_type;
    in_ch.symbol      <= rq.symbol;
    in_ch.beneficiary <= rq.beneficiary;
    in_ch.now         <= rq.now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(rq);
  endtask

  // Drop valid and wait until every verdict has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic load_settings(input logic [COUNT_W-1:0] lim, input logic [15:0] cool,
                               input logic [15:0] hold);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_DISPLACEMENTS;
    cfg_data  <= {junk, lim};
    @(posedge clk);
    cfg_index <= CFG_COOLDOWN_SECONDS;
    cfg_data  <= cool;
    @(posedge clk);
    cfg_index <= CFG_HOLD_SECONDS;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_limits(lim, cool, hold);
    settings_used++;
  endtask

  // Displace, then probe the victim, the heir and a bystander
  task automatic run_episode(output int n);
    logic [SYM_W-1:0] victim;
    logic [SYM_W-1:0] heir;
    logic [SYM_W-1:0] other;
    int               steps;
    victim = pick_symbol();
    heir   = pick_symbol();
    other  = pick_symbol();
    steps  = $urandom_range(2, 5);
    issue(REQ_DISPLACE, victim, heir, advance_clock());
    for (int k = 0; k < steps; k++) begin
      case ($urandom_range(0, 4))
        0:       issue(REQ_ADMIT, victim, SYM_W'($urandom), advance_clock());
        1:       issue(REQ_CHECK, victim, SYM_W'($urandom), advance_clock());
        2:       issue(REQ_ADMIT, heir, SYM_W'($urandom), advance_clock());
        3:       issue(REQ_ADMIT, other, SYM_W'($urandom), advance_clock());
        default: issue(REQ_CHECK, other, SYM_W'($urandom), advance_clock());
      endcase
    end
    n = steps + 1;
  endtask

  // Mix displacement episodes with loose single requests
  task automatic random_phase(input int quota);
    int     made;
    int     n;
    req_e_t kind;
    made = 0;
    while (made < quota) begin
      if ($urandom_range(0, 9) < 6) begin
        run_episode(n);
        made += n;
      end else begin
        case ($urandom_range(0, 15))
          0:             kind = REQ_DAY_CLR;
          1, 2, 3, 4, 5: kind = REQ_ADMIT;
          6, 7, 8, 9:    kind = REQ_DISPLACE;
          default:       kind = REQ_CHECK;
        endcase
        issue(kind, pick_symbol(), pick_symbol(), advance_clock());
        made++;
      end
    end
  endtask

  // Accept results with random back-pressure and one long hold-off
  initial begin : result_sink
    int      stall;
    bit      take;
    bit      held_off;
    result_t got;
    stall    = 0;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status             = status_e_t'(out_ch.status);
        got.reserved_symbol    = out_ch.reserved_symbol;
        got.seconds_left       = out_ch.seconds_left;
        got.displacement_count = out_ch.displacement_count;
        board.check_verdict(got);
      end
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        stall    = 300;
      end
      if (stall > 0) begin
        stall--;
        take = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        take = 1'b1;
      end else begin
        stall = pick_gap();
        take  = 1'b0;
      end
      out_ch.ready <= take;
    end
  end

  // Stimulus
  initial begin : stimulus
    settings_used     = 0;
    no_idle           = 1'b0;
    hold_off_req      = 1'b0;
    t_clock           = 32'd10;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_MAX_DISPLACEMENTS;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_ADMIT;
    in_ch.symbol      <= '0;
    in_ch.beneficiary <= '0;
    in_ch.now         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every request kind, priorities, expiry, time saturation
    load_settings(8'd2, 16'd10, 16'd0);
    issue(REQ_ADMIT, 12'd0, SYM_NONE, 32'd0);
    issue(REQ_CHECK, SYM_NONE, 12'd0, 32'd0);
    issue(REQ_DISPLACE, 12'd5, 12'd6, 32'd100);
    issue(REQ_ADMIT, 12'd5, 12'd0, 32'd105);
    issue(REQ_CHECK, 12'd5, 12'd0, 32'd105);
    issue(REQ_ADMIT, 12'd7, 12'd0, 32'd106);
    issue(REQ_ADMIT, 12'd6, 12'd0, 32'd107);
    issue(REQ_CHECK, 12'd5, 12'd0, 32'd108);
    issue(REQ_ADMIT, 12'd5, 12'd0, 32'd110);
    issue(REQ_DISPLACE, SYM_NONE, SYM_NONE, 32'd200);
    issue(REQ_CHECK, 12'd1, 12'd0, 32'd201);
    issue(REQ_DISPLACE, 12'd0, SYM_NONE, 32'hFFFF_FFF8);
    issue(REQ_ADMIT, 12'd0, 12'd0, 32'hFFFF_FFFE);
    issue(REQ_DISPLACE, SYM_NONE - 1'b1, 12'd0, 32'hFFFF_FFF0);
    issue(REQ_ADMIT, SYM_NONE, 12'd0, 32'hFFFF_FFF1);
    issue(REQ_ADMIT, 12'd0, 12'd0, 32'hFFFF_FFF2);
    issue(REQ_DAY_CLR, SYM_NONE, SYM_NONE, 32'hFFFF_FFF3);
    issue(REQ_CHECK, SYM_NONE - 1'b1, 12'd0, 32'hFFFF_FFF4);
    issue(REQ_ADMIT, 12'd0, 12'd0, 32'hFFFF_FFFF);
    issue(REQ_DISPLACE, 12'd1, 12'd2, 32'd1000);
    issue(REQ_ADMIT, 12'd3, 12'd0, 32'd1060);
    issue(REQ_CHECK, 12'd1, 12'd0, 32'd1005);
    issue(REQ_ADMIT, 12'd1, 12'd0, 32'd1009);
    settle();

    // Run the day tag around at least once with long cooldowns left armed
    load_settings(8'd0, 16'd1000, 16'd0);
    t_clock = 32'd5000;
    for (int i = 0; i < 260; i++) begin
      if (i % 20 == 0) issue(REQ_DISPLACE, SYM_W'(i / 20), SYM_NONE, t_clock);
      issue(REQ_DAY_CLR, SYM_W'($urandom), SYM_W'($urandom), t_clock);
      if (i % 20 == 10) begin
        issue(REQ_CHECK, SYM_W'(i / 20), SYM_NONE, t_clock);
        issue(REQ_ADMIT, SYM_W'(i / 20), SYM_NONE, t_clock);
      end
      t_clock = t_clock + 3;
    end
    for (int s = 0; s < 14; s++) begin
      issue(REQ_CHECK, SYM_W'(s), SYM_NONE, t_clock);
      issue(REQ_ADMIT, SYM_W'(s), SYM_NONE, t_clock);
    end
    settle();

    // Random phases over a spread of settings
    load_settings(8'd0, 16'd40, 16'd0);
    random_phase(58);
    settle();
    load_settings(8'd255, 16'hFFFF, 16'hFFFF);
    random_phase(58);
    settle();
    load_settings(8'd1, 16'd0, 16'd1);
    random_phase(58);
    settle();
    load_settings(8'd4, 16'd120, 16'd30);
    random_phase(58);
    settle();
    load_settings(8'($urandom_range(0, 8)), 16'($urandom_range(1, 300)),
                  16'($urandom_range(0, 200)));
    hold_off_req = 1'b1;
    random_phase(58);
    settle();
    no_idle = 1'b1;
    load_settings(8'd0, 16'd25, 16'hFFFF);
    random_phase(58);
    settle();
    no_idle = 1'b0;
    repeat (6) @(posedge clk);

    $display("Covered %0d admits, %0d displacements, %0d day clears, %0d checks under %0d settings",
             board.req_seen[REQ_ADMIT], board.req_seen[REQ_DISPLACE],
             board.req_seen[REQ_DAY_CLR], board.req_seen[REQ_CHECK], settings_used);
    $display("Compared %0d results: %0d open, %0d cooling, %0d reserved, %0d at limit",
             board.compared, board.status_seen[ST_OPEN], board.status_seen[ST_COOLING],
             board.status_seen[ST_RESERVED], board.status_seen[ST_LIMIT]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
